// File: rtl/base64url_stream_decoder_defines.svh
// Shared assertion macros
`ifndef BASE64URL_STREAM_DECODER_DEFINES_SVH
`define BASE64URL_STREAM_DECODER_DEFINES_SVH

// same-cycle implication
`define B64D_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d check failed");

// next-cycle implication
`define B64D_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d check failed");

`endif

// File: rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    localparam int unsigned SextetW = 6;
    localparam int unsigned ByteW   = 8;

    localparam logic [SextetW-1:0] LOWER_BASE = 6'd26;
    localparam logic [SextetW-1:0] DIGIT_BASE = 6'd52;
    localparam logic [SextetW-1:0] DASH_VAL   = 6'd62;
    localparam logic [SextetW-1:0] USCORE_VAL = 6'd63;

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2,
        POS_FOURTH = 2'd3
    } grp_pos_t;

    typedef struct packed {
        logic [SextetW-1:0] sextet;
        logic               ok;
        logic               final_req;
    } sym_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic sym_t map_symbol(input logic [ByteW-1:0] ch, input logic fin);
        sym_t s;
        s.sextet    = '0;
        s.ok        = 1'b0;
        s.final_req = fin;
        if (ch >= 8'h41 && ch <= 8'h5a)
        begin
            s.sextet = 6'(ch - 8'h41);
            s.ok     = 1'b1;
        end
        else if (ch >= 8'h61 && ch <= 8'h7a)
        begin
            s.sextet = 6'(ch - 8'h61) + LOWER_BASE;
            s.ok     = 1'b1;
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            s.sextet = 6'(ch - 8'h30) + DIGIT_BASE;
            s.ok     = 1'b1;
        end
        else if (ch == 8'h2d)
        begin
            s.sextet = DASH_VAL;
            s.ok     = 1'b1;
        end
        else if (ch == 8'h5f)
        begin
            s.sextet = USCORE_VAL;
            s.ok     = 1'b1;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/base64url_stream_decoder.sv
// Characters are queued, then decoded into the output register when popped.
// Throughput: one character per cycle sustained while out_ready stays high.
// Set by the 2-entry queue between the symbol mapper and the group decoder.
// Reset: rst_n clears queue pointers, group position, sticky error, output valid.
`default_nettype none
`include "base64url_stream_decoder_defines.svh"

module base64url_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   symbol,
    input  wire logic         final_req,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        byte_out,
    output logic              byte_ok,
    output logic              done_res,
    output logic              bad
);

    q_stat_t q_stat;
    logic    push;
    sym_t    push_data;
    logic    pop;
    sym_t    pop_data;

    b64d_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .symbol    (symbol),
        .final_req (final_req),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    b64d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .byte_out  (byte_out),
        .byte_ok   (byte_ok),
        .done_res  (done_res),
        .bad       (bad)
    );

    `B64D_ASSERT_IMP(a_bad_only_done, clk, rst_n, out_valid && bad, done_res)
    `B64D_ASSERT_IMP(a_bad_no_byte, clk, rst_n, out_valid && bad, !byte_ok)
    `B64D_ASSERT_IMP(a_mid_has_byte, clk, rst_n, out_valid && !done_res, byte_ok)
    `B64D_ASSERT_NXT(a_queue_drains, clk, rst_n, q_stat.full && pop, !q_stat.full || push)

endmodule

`default_nettype wire

// File: rtl/b64d_front.sv
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [ByteW-1:0] symbol,
    input  wire logic             final_req,
    input  wire q_stat_t          q_stat,
    output logic                  push,
    output sym_t                  push_data
);

    always_comb
    begin
        in_ready  = !q_stat.full;
        push      = in_valid && !q_stat.full;
        push_data = map_symbol(symbol, final_req);
    end

endmodule

`default_nettype wire

// File: rtl/b64d_queue.sv
`default_nettype none

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire sym_t    push_data,
    input  wire logic    pop,
    output sym_t         pop_data,
    output q_stat_t      q_stat
);

    sym_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg ^ push;
        rd_ptr_next  = rd_ptr_reg ^ pop;
        count_next   = count_reg + {1'b0, push} - {1'b0, pop};
        pop_data     = entry_reg[rd_ptr_reg];
        q_stat.empty = (count_reg == 2'd0);
        q_stat.full  = (count_reg == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64d_back.sv
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire q_stat_t      q_stat,
    input  wire sym_t         pop_data,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [ByteW-1:0]  byte_out,
    output logic              byte_ok,
    output logic              done_res,
    output logic              bad
);

    grp_pos_t           pos_reg, pos_next;
    logic [SextetW-1:0] held_reg, held_next;
    logic               third_reg, third_next;
    logic               err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic [ByteW-1:0]   byte_reg, byte_next;
    logic               ok_reg, ok_next;
    logic               done_reg, done_next;
    logic               bad_reg, bad_next;

    logic               have;
    logic [ByteW-1:0]   dec_byte;
    logic               fail;

    always_comb
    begin
        pop        = !q_stat.empty && (!out_valid_reg || out_ready);
        pos_next   = pos_reg;
        held_next  = held_reg;
        third_next = third_reg;
        err_next   = err_reg;
        have       = 1'b0;
        dec_byte   = '0;
        fail       = 1'b0;

        out_valid_next = out_valid_reg && !out_ready;
        byte_next      = byte_reg;
        ok_next        = ok_reg;
        done_next      = done_reg;
        bad_next       = bad_reg;

        if (pop)
        begin
            unique case (pos_reg)
                POS_FIRST:
                begin
                    err_next  = err_reg || !pop_data.ok;
                    held_next = pop_data.sextet;
                end
                POS_SECOND:
                begin
                    err_next  = err_reg || !pop_data.ok;
                    have      = pop_data.ok && !err_reg;
                    dec_byte  = {held_reg, pop_data.sextet[5:4]};
                    held_next = pop_data.sextet;
                end
                POS_THIRD:
                begin
                    third_next = pop_data.ok;
                    have       = pop_data.ok && !err_reg;
                    dec_byte   = {held_reg[3:0], pop_data.sextet[5:2]};
                    held_next  = pop_data.sextet;
                end
                POS_FOURTH:
                begin
                    have     = pop_data.ok && third_reg && !err_reg;
                    dec_byte = {held_reg[1:0], pop_data.sextet};
                end
            endcase
            pos_next = grp_pos_t'(pos_reg + 2'd1);

            if (pop_data.final_req)
            begin
                // stream ending one char into a group cannot form a byte
                fail           = err_next || (pos_next == POS_SECOND);
                out_valid_next = 1'b1;
                ok_next        = have && !fail;
                byte_next      = (have && !fail) ? dec_byte : '0;
                done_next      = 1'b1;
                bad_next       = fail;
                pos_next       = POS_FIRST;
                held_next      = '0;
                third_next     = 1'b0;
                err_next       = 1'b0;
            end
            else if (have)
            begin
                out_valid_next = 1'b1;
                ok_next        = 1'b1;
                byte_next      = dec_byte;
                done_next      = 1'b0;
                bad_next       = 1'b0;
            end
        end

        out_valid = out_valid_reg;
        byte_out  = byte_reg;
        byte_ok   = ok_reg;
        done_res  = done_reg;
        bad       = bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_FIRST;
            held_reg      <= '0;
            third_reg     <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            third_reg     <= third_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        ok_reg   <= ok_next;
        done_reg <= done_next;
        bad_reg  <= bad_next;
    end

endmodule

`default_nettype wire

// File: tb/b64d_stream_checker.sv
`timescale 1ns / 100ps

module b64d_stream_checker
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       final_req,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] byte_out,
    input  logic       byte_ok,
    input  logic       done_res,
    input  logic       bad,
    output int         fail_count,
    output int         expected_left
);

    typedef struct packed {
        logic [7:0] data;
        logic       data_ok;
        logic       last;
        logic       failed;
    } dec_res_t;

    dec_res_t   decoded_q[$];
    grp_pos_t   pos;
    logic [5:0] held;
    logic       third_ok;
    logic       err_sticky;

    initial
    begin
        fail_count    = 0;
        expected_left = 0;
    end

    function automatic logic sextet_of(input logic [7:0] ch, output logic [5:0] val);
        val = '0;
        if (ch >= "A" && ch <= "Z")
            val = 6'(ch - "A");
        else if (ch >= "a" && ch <= "z")
            val = 6'(ch - "a") + LOWER_BASE;
        else if (ch >= "0" && ch <= "9")
            val = 6'(ch - "0") + DIGIT_BASE;
        else if (ch == "-")
            val = DASH_VAL;
        else if (ch == "_")
            val = USCORE_VAL;
        else
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic add_expected(input dec_res_t r);
        decoded_q = {decoded_q, r};
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic fin);
        logic [5:0] v;
        logic       ok;
        logic       have;
        logic       fail;
        logic [7:0] b;
        dec_res_t   r;
        ok   = sextet_of(ch, v);
        have = 1'b0;
        b    = '0;
        case (pos)
            POS_FIRST:
            begin
                if (!ok)
                    err_sticky = 1'b1;
                held = v;
            end
            POS_SECOND:
            begin
                if (!ok)
                    err_sticky = 1'b1;
                else if (!err_sticky)
                begin
                    b    = {held, v[5:4]};
                    have = 1'b1;
                end
                held = v;
            end
            POS_THIRD:
            begin
                third_ok = ok;
                if (ok && !err_sticky)
                begin
                    b    = {held[3:0], v[5:2]};
                    have = 1'b1;
                end
                held = v;
            end
            default:
            begin
                if (ok && third_ok && !err_sticky)
                begin
                    b    = {held[1:0], v};
                    have = 1'b1;
                end
            end
        endcase
        pos = grp_pos_t'(pos + 2'd1);
        if (fin)
        begin
            fail = err_sticky || (pos == POS_SECOND);
            if (fail)
            begin
                have = 1'b0;
                b    = '0;
            end
            r.data    = b;
            r.data_ok = have;
            r.last    = 1'b1;
            r.failed  = fail;
            add_expected(r);
            pos        = POS_FIRST;
            held       = '0;
            third_ok   = 1'b0;
            err_sticky = 1'b0;
        end
        else if (have)
        begin
            r.data    = b;
            r.data_ok = 1'b1;
            r.last    = 1'b0;
            r.failed  = 1'b0;
            add_expected(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dec_res_t exp_r;
        if (!rst_n)
        begin
            pos        = POS_FIRST;
            held       = '0;
            third_ok   = 1'b0;
            err_sticky = 1'b0;
            decoded_q.delete();
            expected_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected transaction byte=%h ok=%b done=%b bad=%b",
                                 $realtime, byte_out, byte_ok, done_res, bad);
                end
                else
                begin
                    exp_r = decoded_q.pop_front();
                    if (byte_out !== exp_r.data || byte_ok !== exp_r.data_ok ||
                        done_res !== exp_r.last || bad !== exp_r.failed)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp byte=%h ok=%b done=%b bad=%b",
                                     $realtime, exp_r.data, exp_r.data_ok, exp_r.last,
                                     exp_r.failed,
                                     " got byte=%h ok=%b done=%b bad=%b",
                                     byte_out, byte_ok, done_res, bad);
                    end
                end
            end
            if (in_valid && in_ready)
                decode_char(symbol, final_req);
            expected_left = decoded_q.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import b64d_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int NUM_CHARS   = 1250;
    localparam int IDLE_PCT    = 11;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] symbol;
    logic       final_req;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] byte_out;
    logic       byte_ok;
    logic       done_res;
    logic       bad;
    logic       steady;
    int         fail_count;
    int         expected_left;
    int         stall_cycles;

    base64url_stream_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .symbol    (symbol),
        .final_req (final_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .byte_out  (byte_out),
        .byte_ok   (byte_ok),
        .done_res  (done_res),
        .bad       (bad)
    );

    b64d_stream_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .symbol        (symbol),
        .final_req     (final_req),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_out      (byte_out),
        .byte_ok       (byte_ok),
        .done_res      (done_res),
        .bad           (bad),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic logic [7:0] alpha_char(input int unsigned idx);
        if (idx < LOWER_BASE)
            return 8'("A" + idx);
        if (idx < DIGIT_BASE)
            return 8'("a" + idx - LOWER_BASE);
        if (idx < DASH_VAL)
            return 8'("0" + idx - DIGIT_BASE);
        if (idx == DASH_VAL)
            return "-";
        return "_";
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_char(input logic [7:0] ch, input logic fin);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        symbol    = ch;
        final_req = fin;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    initial
    begin
        int         n;
        int         len;
        logic       junk;
        logic [7:0] ch;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        symbol    = '0;
        final_req = 1'b0;
        out_ready = 1'b0;
        steady    = 1'b0;
        stall_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // stream ends after first char of a group
        send_str("A");
        send_str("__");
        send_str("-z09");
        // invalid third, then invalid fourth
        send_str("QU!x");
        send_str("QUJ*");
        // invalid first char, later bytes suppressed, ends mid-group
        send_char(8'h00, 1'b0);
        send_str("BCDEF");
        // invalid second char
        send_char("Z", 1'b0);
        send_char(8'hff, 1'b0);
        send_str("ya");

        n = 0;
        while (n < NUM_CHARS)
        begin
            steady = (n >= 500 && n < 750);
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                 : $urandom_range(1, 12);
            junk   = ($urandom_range(0, 99) < 15);
            for (int k = 0; k < len; k++)
            begin
                if (junk || $urandom_range(0, 99) < 4)
                    ch = 8'($urandom_range(0, 255));
                else
                    ch = alpha_char($urandom_range(0, 63));
                send_char(ch, k == len - 1);
            end
            n += len;
        end
        in_valid = 1'b0;
        steady   = 1'b0;

        while (expected_left != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
